FILE: hdl/efp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the escape-time fractal pixel block.
package efp_pkg;

   localparam int WORD_W  = 32;
   localparam int PROD_W  = 64;
   localparam int WIDE_W  = 66;
   localparam int COUNT_W = 16;
   localparam int STEP_W  = 31;
   localparam int INDEX_W = 3;

   typedef enum logic [INDEX_W-1:0] {
      REG_LEFT_EDGE      = 3'd0,
      REG_BOTTOM_EDGE    = 3'd1,
      REG_STEP_X         = 3'd2,
      REG_STEP_Y         = 3'd3,
      REG_MAX_ITERATIONS = 3'd4,
      REG_POWER_MODE     = 3'd5
   } reg_index_type;

   localparam logic signed [WORD_W-1:0] LEFT_RESET   = -32'sd295279002;
   localparam logic signed [WORD_W-1:0] BOTTOM_RESET = -32'sd228170138;
   localparam logic [STEP_W-1:0]        STEP_RESET   = 31'd445645;
   localparam logic [COUNT_W-1:0]       ITER_RESET   = 16'd256;
   localparam logic                     POWER_RESET  = 1'b0;

   typedef enum logic [1:0] {
      OP_MAP = 2'd0,
      OP_ZZ  = 2'd1,
      OP_TZ  = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        capture_pixel;
      mul_sel_type mul_sel;
      logic        load_c;
      logic        save_t;
      logic        update_z;
      logic        load_result;
   } cmd_type;

   typedef struct packed {
      logic escape;
      logic zero_limit;
      logic last_iter;
      logic power;
   } status_type;

   function automatic logic signed [WIDE_W-1:0] ext_word(input logic signed [WORD_W-1:0] w);
      return {{(WIDE_W-WORD_W){w[WORD_W-1]}}, w};
   endfunction

   function automatic logic signed [WIDE_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
      return {{(WIDE_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   // Clamps a wide two's complement value to the 32-bit word range.
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
      logic all_one;
      logic all_zero;
      all_one  = &v[WIDE_W-1:WORD_W-1];
      all_zero = ~|v[WIDE_W-1:WORD_W-1];
      if (all_one || all_zero) begin
         return v[WORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

endpackage

FILE: hdl/efp_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces for pixel requests, iteration count responses and register writes.
interface efp_req_if #(
   parameter int PIXEL_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_x;
   logic [PIXEL_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface efp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [efp_pkg::COUNT_W-1:0]  iteration_count;

   modport source (output valid, output iteration_count, input ready);
   modport sink (input valid, input iteration_count, output ready);
endinterface

interface efp_csr_if;
   logic                         valid;
   logic                         ready;
   logic [efp_pkg::INDEX_W-1:0]  index;
   logic [efp_pkg::WORD_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/escape_time_fractal_pixel.sv
`timescale 1ns / 1ps
// Top level of the escape-time fractal pixel evaluator.
// One pixel transaction is worked on at a time. After acceptance the pixel is mapped to c in
// the S_MAP and S_LOAD states, then each iteration passes S_SQ_MUL and S_SQ_EVAL in square mode
// and adds S_CU_MUL and S_CU_EVAL in cubic mode, since the four registered 32x32 multipliers are
// used once for z*z and again for (z*z)*z. The response register lets the next pixel start while
// the previous count waits. Register writes must be made while the block is idle.
module escape_time_fractal_pixel #(
   parameter int PIXEL_BITS = 12,
   parameter int FRAC_BITS  = 27
) (
   input  logic       clock,
   input  logic       reset,
   efp_req_if.sink    req_bus,
   efp_rsp_if.source  rsp_bus,
   efp_csr_if.sink    csr_bus
);

   efp_pkg::cmd_type    cmd;
   efp_pkg::status_type status;
   logic                csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;

   efp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   efp_datapath #(
      .PIXEL_BITS (PIXEL_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .pixel_x         (req_bus.pixel_x),
      .pixel_y         (req_bus.pixel_y),
      .cmd             (cmd),
      .status          (status),
      .iteration_count (rsp_bus.iteration_count)
   );

endmodule

FILE: hdl/efp_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, pixel mapping, complex multiply and escape test.
module efp_datapath #(
   parameter int PIXEL_BITS = 12,
   parameter int FRAC_BITS  = 27
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [efp_pkg::INDEX_W-1:0]        csr_index,
   input  logic [efp_pkg::WORD_W-1:0]         csr_data,
   input  logic [PIXEL_BITS-1:0]              pixel_x,
   input  logic [PIXEL_BITS-1:0]              pixel_y,
   input  efp_pkg::cmd_type                   cmd,
   output efp_pkg::status_type                status,
   output logic [efp_pkg::COUNT_W-1:0]        iteration_count
);

   localparam logic signed [efp_pkg::WIDE_W-1:0] ESC_LIMIT =
      efp_pkg::WIDE_W'(4) << FRAC_BITS;

   logic signed [efp_pkg::WORD_W-1:0]  left_ff;
   logic signed [efp_pkg::WORD_W-1:0]  bottom_ff;
   logic [efp_pkg::STEP_W-1:0]         step_x_ff;
   logic [efp_pkg::STEP_W-1:0]         step_y_ff;
   logic [efp_pkg::COUNT_W-1:0]        max_iter_ff;
   logic                               power_ff;

   logic [PIXEL_BITS-1:0]              px_ff;
   logic [PIXEL_BITS-1:0]              py_ff;
   logic signed [efp_pkg::WORD_W-1:0]  cr_ff;
   logic signed [efp_pkg::WORD_W-1:0]  ci_ff;
   logic signed [efp_pkg::WORD_W-1:0]  zr_ff;
   logic signed [efp_pkg::WORD_W-1:0]  zi_ff;
   logic signed [efp_pkg::WORD_W-1:0]  tr_ff;
   logic signed [efp_pkg::WORD_W-1:0]  ti_ff;
   logic signed [efp_pkg::PROD_W-1:0]  p_rr_ff;
   logic signed [efp_pkg::PROD_W-1:0]  p_ii_ff;
   logic signed [efp_pkg::PROD_W-1:0]  p_ri_ff;
   logic signed [efp_pkg::PROD_W-1:0]  p_ir_ff;
   logic signed [efp_pkg::PROD_W-1:0]  p_rr_in;
   logic signed [efp_pkg::PROD_W-1:0]  p_ii_in;
   logic signed [efp_pkg::PROD_W-1:0]  p_ri_in;
   logic signed [efp_pkg::PROD_W-1:0]  p_ir_in;
   logic [efp_pkg::COUNT_W-1:0]        iter_ff;
   logic [efp_pkg::COUNT_W-1:0]        result_ff;

   logic signed [efp_pkg::WORD_W-1:0]  a_re;
   logic signed [efp_pkg::WORD_W-1:0]  a_im;
   logic signed [efp_pkg::WORD_W-1:0]  b_re;
   logic signed [efp_pkg::WORD_W-1:0]  b_im;

   logic signed [efp_pkg::PROD_W-1:0]  s_rr;
   logic signed [efp_pkg::PROD_W-1:0]  s_ii;
   logic signed [efp_pkg::PROD_W-1:0]  s_ri;
   logic signed [efp_pkg::PROD_W-1:0]  s_ir;
   logic signed [efp_pkg::WIDE_W-1:0]  mag;
   logic signed [efp_pkg::WORD_W-1:0]  t_re;
   logic signed [efp_pkg::WORD_W-1:0]  t_im;
   logic signed [efp_pkg::WORD_W-1:0]  zr_in;
   logic signed [efp_pkg::WORD_W-1:0]  zi_in;
   logic signed [efp_pkg::WORD_W-1:0]  cr_in;
   logic signed [efp_pkg::WORD_W-1:0]  ci_in;

   always_comb begin
      case (cmd.mul_sel)
         efp_pkg::OP_MAP: begin
            a_re = signed'(efp_pkg::WORD_W'(px_ff));
            a_im = signed'(efp_pkg::WORD_W'(py_ff));
            b_re = signed'({1'b0, step_x_ff});
            b_im = signed'({1'b0, step_y_ff});
         end
         efp_pkg::OP_TZ: begin
            a_re = tr_ff;
            a_im = ti_ff;
            b_re = zr_ff;
            b_im = zi_ff;
         end
         default: begin
            a_re = zr_ff;
            a_im = zi_ff;
            b_re = zr_ff;
            b_im = zi_ff;
         end
      endcase
   end

   // In the mapping cycle the real and imaginary products carry pixel times step.
   assign p_rr_in = efp_pkg::PROD_W'(a_re) * efp_pkg::PROD_W'(b_re);
   assign p_ii_in = efp_pkg::PROD_W'(a_im) * efp_pkg::PROD_W'(b_im);
   assign p_ri_in = efp_pkg::PROD_W'(a_re) * efp_pkg::PROD_W'(b_im);
   assign p_ir_in = efp_pkg::PROD_W'(a_im) * efp_pkg::PROD_W'(b_re);

   assign s_rr = p_rr_ff >>> FRAC_BITS;
   assign s_ii = p_ii_ff >>> FRAC_BITS;
   assign s_ri = p_ri_ff >>> FRAC_BITS;
   assign s_ir = p_ir_ff >>> FRAC_BITS;

   assign mag = efp_pkg::ext_prod(s_rr) + efp_pkg::ext_prod(s_ii);

   assign t_re = efp_pkg::sat_word(
      efp_pkg::ext_word(efp_pkg::sat_word(efp_pkg::ext_prod(s_rr)))
      - efp_pkg::ext_word(efp_pkg::sat_word(efp_pkg::ext_prod(s_ii))));
   assign t_im = efp_pkg::sat_word(
      efp_pkg::ext_word(efp_pkg::sat_word(efp_pkg::ext_prod(s_ri)))
      + efp_pkg::ext_word(efp_pkg::sat_word(efp_pkg::ext_prod(s_ir))));

   assign zr_in = efp_pkg::sat_word(efp_pkg::ext_word(t_re) + efp_pkg::ext_word(cr_ff));
   assign zi_in = efp_pkg::sat_word(efp_pkg::ext_word(t_im) + efp_pkg::ext_word(ci_ff));

   assign cr_in = efp_pkg::sat_word(efp_pkg::ext_prod(p_rr_ff) + efp_pkg::ext_word(left_ff));
   assign ci_in = efp_pkg::sat_word(efp_pkg::ext_prod(p_ii_ff) + efp_pkg::ext_word(bottom_ff));

   assign status.escape     = (mag >= ESC_LIMIT);
   assign status.zero_limit = (max_iter_ff == '0);
   assign status.last_iter  =
      ((efp_pkg::COUNT_W + 1)'(iter_ff) + 1'b1) == (efp_pkg::COUNT_W + 1)'(max_iter_ff);
   assign status.power      = power_ff;

   assign iteration_count = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= efp_pkg::LEFT_RESET;
         bottom_ff   <= efp_pkg::BOTTOM_RESET;
         step_x_ff   <= efp_pkg::STEP_RESET;
         step_y_ff   <= efp_pkg::STEP_RESET;
         max_iter_ff <= efp_pkg::ITER_RESET;
         power_ff    <= efp_pkg::POWER_RESET;
      end else if (csr_write) begin
         case (csr_index)
            efp_pkg::REG_LEFT_EDGE:      left_ff     <= signed'(csr_data);
            efp_pkg::REG_BOTTOM_EDGE:    bottom_ff   <= signed'(csr_data);
            efp_pkg::REG_STEP_X:         step_x_ff   <= csr_data[efp_pkg::STEP_W-1:0];
            efp_pkg::REG_STEP_Y:         step_y_ff   <= csr_data[efp_pkg::STEP_W-1:0];
            efp_pkg::REG_MAX_ITERATIONS: max_iter_ff <= csr_data[efp_pkg::COUNT_W-1:0];
            efp_pkg::REG_POWER_MODE:     power_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p_rr_ff <= p_rr_in;
      p_ii_ff <= p_ii_in;
      p_ri_ff <= p_ri_in;
      p_ir_ff <= p_ir_in;
      if (cmd.capture_pixel) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
      end
      if (cmd.load_c) begin
         cr_ff   <= cr_in;
         ci_ff   <= ci_in;
         zr_ff   <= '0;
         zi_ff   <= '0;
         iter_ff <= '0;
      end else if (cmd.update_z) begin
         zr_ff   <= zr_in;
         zi_ff   <= zi_in;
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.save_t) begin
         tr_ff <= t_re;
         ti_ff <= t_im;
      end
      if (cmd.load_result) begin
         result_ff <= iter_ff;
      end
   end

endmodule

FILE: hdl/efp_controller.sv
`timescale 1ns / 1ps
// Controller state machine that sequences mapping, iteration and result delivery.
module efp_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  efp_pkg::status_type  status,
   output efp_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAP,
      S_LOAD,
      S_SQ_MUL,
      S_SQ_EVAL,
      S_CU_MUL,
      S_CU_EVAL,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd               = '0;
      cmd.mul_sel       = efp_pkg::OP_ZZ;
      state_in          = state_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            cmd.capture_pixel = req_valid;
            if (req_valid) begin
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            cmd.mul_sel = efp_pkg::OP_MAP;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_c = 1'b1;
            state_in   = status.zero_limit ? S_DONE : S_SQ_MUL;
         end
         S_SQ_MUL: begin
            cmd.mul_sel = efp_pkg::OP_ZZ;
            state_in    = S_SQ_EVAL;
         end
         S_SQ_EVAL: begin
            if (status.escape) begin
               state_in = S_DONE;
            end else if (status.power) begin
               cmd.save_t = 1'b1;
               state_in   = S_CU_MUL;
            end else begin
               cmd.update_z = 1'b1;
               state_in     = status.last_iter ? S_DONE : S_SQ_MUL;
            end
         end
         S_CU_MUL: begin
            cmd.mul_sel = efp_pkg::OP_TZ;
            state_in    = S_CU_EVAL;
         end
         S_CU_EVAL: begin
            cmd.update_z = 1'b1;
            state_in     = status.last_iter ? S_DONE : S_SQ_MUL;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/efp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the escape-time fractal pixel block and its bind statement.
module efp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [efp_pkg::COUNT_W-1:0] rsp_count
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response valid dropped before the transaction completed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_count))
      else $error("Response count changed while the transaction was stalled.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A second request was accepted while a pixel was in progress.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("A response appeared sooner than the pixel mapping allows.");

   assert property (@(posedge clock)
      $fell(reset) |-> req_ready)
      else $error("The block is not ready for a request after reset.");

endmodule

bind escape_time_fractal_pixel efp_checker u_efp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_count (rsp_bus.iteration_count)
);
